[hdl/pcg32_ranged_random_generator_macros.svh]
// ---------------------------------------------------------------------------
// pcg32_ranged_random_generator_macros.svh
// Assertion macros shared by the generator RTL. Define NO_ASSERTIONS to drop
// every check from the build.
// ---------------------------------------------------------------------------
`ifndef PCG32_RANGED_RANDOM_GENERATOR_MACROS_SVH
`define PCG32_RANGED_RANDOM_GENERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a consequent in the same cycle as its antecedent
`define PCG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check a consequent in the cycle after its antecedent
`define PCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define PCG_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PCG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/pcg32rr_pkg.sv]
// ---------------------------------------------------------------------------
// pcg32rr_pkg
// Types, constants and the output permutation of the PCG32 ranged generator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcg32rr_pkg;

    // Word sizes
    localparam int WORD_W     = 32;
    localparam int STATE_W    = 64;
    localparam int STREAM_W   = 63;
    localparam int RANGE_W    = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // LCG multiplier, consumed one digit per cycle
    localparam logic [STATE_W-1:0] LCG_MULT = 64'h5851_F42D_4C95_7F2D;
    localparam int DIGIT_W   = 4;
    localparam int MUL_STEPS = STATE_W / DIGIT_W;
    localparam int CNT_W     = 5;
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORD_W - 1);

    // XSH-RR shift amounts
    localparam int XS_SHIFT_A = 18;
    localparam int XS_SHIFT_B = 27;
    localparam int ROT_SHIFT  = 59;

    localparam logic [WORD_W-1:0] WORD_ALL = 32'hFFFF_FFFF;

    // Register reset values
    localparam logic [STATE_W-1:0]  SEED_RESET   = 64'd42;
    localparam logic [STREAM_W-1:0] STREAM_RESET = 63'd54;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEED_STATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STREAM_SELECT = 2'd1;

    // Request actions
    localparam logic ACT_RAW    = 1'b0;
    localparam logic ACT_RANGED = 1'b1;

    typedef struct packed {
        logic                     action;
        logic signed [WORD_W-1:0] range_min;
        logic signed [WORD_W-1:0] range_max;
    } t_req;

    typedef struct packed {
        logic        [WORD_W-1:0] raw_word;
        logic signed [WORD_W-1:0] ranged_value;
        logic                     range_error;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_SEED_LOAD,
        ST_SEED_RUN,
        ST_IDLE,
        ST_LIM_RUN,
        ST_DRAW_LOAD,
        ST_DRAW_RUN,
        ST_EVAL,
        ST_MOD_RUN,
        ST_DONE
    } t_state;

    // Strobes from the sequencer to the datapath
    typedef struct packed {
        logic seed_load;
        logic draw_load;
        logic mul_step;
        logic mul_last;
        logic div_step;
        logic lim_last;
        logic mod_last;
        logic req_ok;
        logic req_bad;
        logic eval_raw;
        logic eval_keep;
        logic out_load;
    } t_ctl;

    // XSH-RR permutation of the old state
    function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] old);
        logic [STATE_W-1:0] mix;
        logic [WORD_W-1:0]  xs;
        logic [4:0]         rot;
        mix = (old >> XS_SHIFT_A) ^ old;
        xs  = WORD_W'(mix >> XS_SHIFT_B);
        rot = 5'(old >> ROT_SHIFT);
        return (xs >> rot) | (xs << (5'd0 - rot));
    endfunction

endpackage

`default_nettype wire

[hdl/pcg32_ranged_random_generator.sv]
// ---------------------------------------------------------------------------
// pcg32_ranged_random_generator
// PCG32 XSH-RR generator returning raw words or uniform integers in a range.
// ---------------------------------------------------------------------------
// One request is in work at a time. The 64-bit LCG step runs digit-serial,
// four multiplier bits per cycle, so a draw is a load, 16 digit steps and
// an evaluate step. A ranged request first finds the rejection limit by a
// bit-serial remainder, then draws (repeated on rejection), then reduces
// the kept draw by a second bit-serial remainder. A request with a bad
// range goes straight to the done state with an error result. After reset
// and after each write to a known register the block reseeds and takes no
// request meanwhile. The output register lets a finished result wait while
// the block returns to idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pcg32_ranged_random_generator_macros.svh"

module pcg32_ranged_random_generator
    import pcg32rr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output      logic                  o_in_ready,
    input  wire t_req                  i_in_data,
    output      logic                  o_out_valid,
    input  wire logic                  i_out_ready,
    output      t_rsp                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;
    t_ctl   ctl;

    logic [STATE_W-1:0]  r_seed;
    logic [STREAM_W-1:0] r_stream;
    logic [STATE_W-1:0]  r_gen;
    logic [STATE_W-1:0]  r_old;
    logic [STATE_W-1:0]  r_acc;
    logic [STATE_W-1:0]  r_mcand;
    logic [STATE_W-1:0]  r_kmul;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_action;
    logic [WORD_W-1:0]   r_lo;
    logic [RANGE_W-1:0]  r_range;
    logic [WORD_W-1:0]   r_limit;
    logic [WORD_W-1:0]   r_rem, n_rem;
    logic [WORD_W-1:0]   r_dvd;
    t_rsp                r_res;
    t_rsp                r_out;
    logic                r_out_valid;

    logic [STATE_W-1:0]         lcg_inc;
    logic                       cfg_hit;
    logic signed [WORD_W:0]     req_span;
    logic                       req_err;
    logic [STATE_W-1:0]         mul_part;
    logic [STATE_W-1:0]         mul_sum;
    logic [WORD_W-1:0]          draw_raw;
    logic                       draw_reject;
    logic [WORD_W-1:0]          div_trial;
    logic                       div_ge;

    // Derived increment and request checks
    assign lcg_inc  = {r_stream, 1'b1};
    assign cfg_hit  = i_cfg_we &&
                      (i_cfg_index == REG_SEED_STATE || i_cfg_index == REG_STREAM_SELECT);
    assign req_span = $signed({i_in_data.range_max[WORD_W-1], i_in_data.range_max}) -
                      $signed({i_in_data.range_min[WORD_W-1], i_in_data.range_min});
    assign req_err  = req_span[WORD_W] || req_span[WORD_W-1] || (req_span == '0);

    // One multiplier digit per cycle
    assign mul_part = r_mcand * STATE_W'(r_kmul[DIGIT_W-1:0]);
    assign mul_sum  = r_acc + mul_part;

    // Permute the old state and test against the rejection limit
    assign draw_raw    = xsh_rr(r_old);
    assign draw_reject = (draw_raw >= r_limit);

    // One restoring remainder step per cycle
    assign div_trial = {r_rem[WORD_W-2:0], r_dvd[WORD_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_range});
    assign n_rem     = div_ge ? (div_trial - {1'b0, r_range}) : div_trial;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SEED_LOAD: n_state = ST_SEED_RUN;
            ST_SEED_RUN:  if (r_cnt == MUL_LAST) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.action == ACT_RAW) begin
                        n_state = ST_DRAW_LOAD;
                    end else if (req_err) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_LIM_RUN;
                    end
                end
            end
            ST_LIM_RUN:   if (r_cnt == DIV_LAST) n_state = ST_DRAW_LOAD;
            ST_DRAW_LOAD: n_state = ST_DRAW_RUN;
            ST_DRAW_RUN:  if (r_cnt == MUL_LAST) n_state = ST_EVAL;
            ST_EVAL: begin
                if (r_action == ACT_RAW) begin
                    n_state = ST_DONE;
                end else if (draw_reject) begin
                    n_state = ST_DRAW_LOAD;
                end else begin
                    n_state = ST_MOD_RUN;
                end
            end
            ST_MOD_RUN:   if (r_cnt == DIV_LAST) n_state = ST_DONE;
            ST_DONE:      if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:      n_state = ST_SEED_LOAD;
        endcase
        // A write to the seed or stream register restarts seeding
        if (cfg_hit) n_state = ST_SEED_LOAD;
    end

    // Sequencer strobes
    always_comb begin
        ctl           = '0;
        ctl.seed_load = (r_state == ST_SEED_LOAD);
        ctl.draw_load = (r_state == ST_DRAW_LOAD);
        ctl.mul_step  = (r_state == ST_SEED_RUN) || (r_state == ST_DRAW_RUN);
        ctl.mul_last  = ctl.mul_step && (r_cnt == MUL_LAST);
        ctl.div_step  = (r_state == ST_LIM_RUN) || (r_state == ST_MOD_RUN);
        ctl.lim_last  = (r_state == ST_LIM_RUN) && (r_cnt == DIV_LAST);
        ctl.mod_last  = (r_state == ST_MOD_RUN) && (r_cnt == DIV_LAST);
        ctl.req_ok    = (r_state == ST_IDLE) && i_in_valid &&
                        (i_in_data.action == ACT_RANGED) && !req_err;
        ctl.req_bad   = (r_state == ST_IDLE) && i_in_valid &&
                        (i_in_data.action == ACT_RANGED) && req_err;
        ctl.eval_raw  = (r_state == ST_EVAL) && (r_action == ACT_RAW);
        ctl.eval_keep = (r_state == ST_EVAL) && (r_action == ACT_RANGED) && !draw_reject;
        ctl.out_load  = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SEED_LOAD;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_seed      <= SEED_RESET;
            r_stream    <= STREAM_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= (ctl.mul_step || ctl.div_step) ? r_cnt + 1'b1 : '0;
            if (ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we && i_cfg_index == REG_SEED_STATE) begin
                r_seed <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == REG_STREAM_SELECT) begin
                r_stream <= i_cfg_data[STREAM_W-1:0];
            end
        end
    end

    // Digit-serial LCG multiply
    always_ff @(posedge i_clk) begin
        if (ctl.seed_load) begin
            r_mcand <= lcg_inc + r_seed;
            r_acc   <= lcg_inc;
            r_kmul  <= LCG_MULT;
        end else if (ctl.draw_load) begin
            r_mcand <= r_gen;
            r_acc   <= lcg_inc;
            r_kmul  <= LCG_MULT;
            r_old   <= r_gen;
        end else if (ctl.mul_step) begin
            r_mcand <= r_mcand << DIGIT_W;
            r_acc   <= mul_sum;
            r_kmul  <= r_kmul >> DIGIT_W;
        end
        if (ctl.mul_last) begin
            r_gen <= mul_sum;
        end
    end

    // Request capture, bit-serial remainder and result assembly
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_action <= i_in_data.action;
            r_lo     <= i_in_data.range_min;
            r_range  <= req_span[RANGE_W-1:0];
        end
        if (ctl.req_ok) begin
            r_rem <= '0;
            r_dvd <= WORD_ALL;
        end else if (ctl.eval_keep) begin
            r_rem <= '0;
            r_dvd <= draw_raw;
        end else if (ctl.div_step) begin
            r_rem <= n_rem;
            r_dvd <= r_dvd << 1;
        end
        if (ctl.lim_last) begin
            r_limit <= WORD_ALL - n_rem;
        end
        if (ctl.req_bad) begin
            r_res <= '{raw_word: '0, ranged_value: '0, range_error: 1'b1};
        end else if (ctl.eval_raw) begin
            r_res <= '{raw_word: draw_raw, ranged_value: '0, range_error: 1'b0};
        end else if (ctl.eval_keep) begin
            r_res.raw_word    <= draw_raw;
            r_res.range_error <= 1'b0;
        end else if (ctl.mod_last) begin
            r_res.ranged_value <= r_lo + n_rem;
        end
        if (ctl.out_load) begin
            r_out <= r_res;
        end
    end

    // Checks
    `PCG_ASSERT_SAME(a_err_zero, i_clk, i_rst_n,
        o_out_valid && o_out_data.range_error,
        o_out_data.raw_word == '0 && o_out_data.ranged_value == '0)
    `PCG_ASSERT_NEXT(a_cfg_reseed, i_clk, i_rst_n, cfg_hit, !o_in_ready)
    `PCG_ASSERT_SAME(a_rem_bound, i_clk, i_rst_n,
        r_state == ST_LIM_RUN || r_state == ST_MOD_RUN, r_rem < {1'b0, r_range})
    `PCG_ASSERT_SAME(a_out_from_done, i_clk, i_rst_n,
        $rose(o_out_valid), $past(r_state) == ST_DONE)

endmodule

`default_nettype wire

[tb/tb_pcg32_ranged_random_generator.sv]
// ---------------------------------------------------------------------------
// tb_pcg32_ranged_random_generator
// Self-checking bench for the PCG32 ranged random generator. A clocked driver
// feeds request transactions from a queue, a clocked monitor takes result
// transactions and compares them with the output of a local model of the
// LCG, the XSH-RR permutation and the rejection sampler. Phases change the
// seed and stream registers and vary the idling on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pcg32_ranged_random_generator
    import pcg32rr_pkg::*;
();

    localparam logic [63:0]           MULTIPLIER    = 64'd6364136223846793005;
    localparam logic [63:0]           SEED_DEFAULT  = 64'd42;
    localparam logic [62:0]           STREAM_DEFAULT = 63'd54;
    localparam logic [CFG_IDX_W-1:0]  REG_SPARE_LO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0]  REG_SPARE_HI  = 2'd3;
    localparam logic signed [32:0]    SPAN_MAX      = 33'sd2147483647;
    localparam longint                WORD_HALF     = 64'sd2147483648;
    localparam int                    CYCLE_LIMIT   = 2000000;
    localparam int                    FLUSH_CYCLES  = 200;
    localparam int                    HOLDOFF_LEN   = 400;

    // Clock, reset and block ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_req                  in_data   = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_rsp                  out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Stimulus and expectation stores
    t_req req_pending[$];
    t_rsp rsp_expected[$];

    // Idling control, percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned holdoff_left   = 0;
    int          cycle_count    = 0;
    int          mismatch_count = 0;

    // Local copy of generator state and registers
    logic [63:0] gen_state;
    logic [63:0] gen_inc;
    logic [63:0] seed_reg;
    logic [62:0] stream_reg;

    pcg32_ranged_random_generator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Advance the LCG and return the permuted old state
    function automatic logic [31:0] draw_word();
        logic [63:0] old;
        logic [31:0] xs;
        logic [4:0]  rot;
        old       = gen_state;
        gen_state = old * MULTIPLIER + gen_inc;
        xs        = 32'(((old >> 18) ^ old) >> 27);
        rot       = old[63:59];
        return 32'({xs, xs} >> rot);
    endfunction

    // Standard PCG seeding from the two registers
    function automatic void reseed_generator();
        gen_inc   = {stream_reg, 1'b1};
        gen_state = '0;
        void'(draw_word());
        gen_state = gen_state + seed_reg;
        void'(draw_word());
    endfunction

    // Work out the result of one request and advance the local state
    function automatic t_rsp predict_response(t_req req);
        t_rsp              rsp;
        logic signed [32:0] span;
        logic [31:0]       range;
        logic [31:0]       limit;
        logic [31:0]       word;
        rsp  = '0;
        span = {req.range_max[31], req.range_max} - {req.range_min[31], req.range_min};
        if (req.action == ACT_RAW) begin
            rsp.raw_word = draw_word();
        end else if (span <= 0 || span > SPAN_MAX) begin
            rsp.range_error = 1'b1;
        end else begin
            range = span[31:0];
            limit = 32'hFFFF_FFFF - (32'hFFFF_FFFF % range);
            // Reject draws in the incomplete top bucket
            do begin
                word = draw_word();
            end while (word >= limit);
            rsp.raw_word     = word;
            rsp.ranged_value = req.range_min + (word % range);
        end
        return rsp;
    endfunction

    // Random request: mostly well-formed ranges of assorted spans
    function automatic t_req make_request();
        t_req        req;
        t_req        swap;
        logic [63:0] pick;
        longint      lo;
        longint      span;
        longint      room;
        int unsigned kind;
        req.action    = 1'($urandom_range(1));
        req.range_min = $urandom;
        req.range_max = $urandom;
        pick          = {$urandom, $urandom};
        kind          = $urandom_range(99);
        if (req.action == ACT_RANGED) begin
            if (kind < 75) begin
                case ($urandom_range(3))
                    0: span = $urandom_range(1, 16);
                    1: span = $urandom_range(17, 65536);
                    2: span = $urandom_range(1, 32'h7FFF_FFFF);
                    default: span = $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
                endcase
                room          = 2 * WORD_HALF - span;
                lo            = -WORD_HALF + longint'(pick % 64'(room));
                req.range_min = 32'(lo);
                req.range_max = 32'(lo + span);
            end else if (kind < 83) begin
                // keep the raw random pair
            end else if (kind < 89) begin
                req.range_max = req.range_min;
            end else if (kind < 95) begin
                if (req.range_min < req.range_max) begin
                    swap          = req;
                    req.range_min = swap.range_max;
                    req.range_max = swap.range_min;
                end
            end else begin
                // Span of 2^31 or more
                lo            = -WORD_HALF + longint'($urandom_range(0, 32'h7FFF_FFFF));
                room          = WORD_HALF - (lo + WORD_HALF);
                req.range_min = 32'(lo);
                req.range_max = 32'(lo + WORD_HALF + longint'(pick % 64'(room)));
            end
        end
        return req;
    endfunction

    task automatic report_failure(string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic push_request(logic action, logic signed [31:0] lo, logic signed [31:0] hi);
        t_req req;
        req.action    = action;
        req.range_min = lo;
        req.range_max = hi;
        req_pending.push_back(req);
    endtask

    task automatic queue_random(int n);
        repeat (n) req_pending.push_back(make_request());
    endtask

    // Hold until every queued transaction has been answered
    task automatic wait_drained();
        @(negedge clk);
        while (req_pending.size() != 0 || in_valid || rsp_expected.size() != 0)
            @(negedge clk);
    endtask

    // Write one register while the block is idle and track the reseed
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_SEED_STATE: begin
                seed_reg = value;
                reseed_generator();
            end
            REG_STREAM_SELECT: begin
                stream_reg = value[62:0];
                reseed_generator();
            end
            default: begin
            end
        endcase
        @(negedge clk);
    endtask

    // Request driver: offer queued transactions, predict on acceptance
    always @(posedge clk) begin : request_driver
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                rsp_expected.push_back(predict_response(in_data));
            if (!in_valid || in_ready) begin
                if (req_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= req_pending.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted transaction with the oldest expectation
    always @(posedge clk) begin : result_monitor
        t_rsp want;
        if (rst_n && out_valid && out_ready) begin
            if (rsp_expected.size() == 0) begin
                report_failure($sformatf("unexpected result %h", out_data));
            end else begin
                want = rsp_expected.pop_front();
                if (out_data.raw_word !== want.raw_word)
                    report_failure($sformatf("raw_word got %h expected %h",
                                             out_data.raw_word, want.raw_word));
                if (out_data.ranged_value !== want.ranged_value)
                    report_failure($sformatf("ranged_value got %0d expected %0d",
                                             out_data.ranged_value, want.ranged_value));
                if (out_data.range_error !== want.range_error)
                    report_failure($sformatf("range_error got %b expected %b",
                                             out_data.range_error, want.range_error));
            end
        end
        out_ready <= rst_n && holdoff_left == 0 && ($urandom_range(99) >= recv_stall_pct);
    end

    // Count down a long receiver hold-off
    always @(posedge clk) begin : holdoff_counter
        if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
    end

    // Abort a hung run
    always @(posedge clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : sequencer
        seed_reg   = SEED_DEFAULT;
        stream_reg = STREAM_DEFAULT;
        reseed_generator();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests on the reset seeding, no idling
        push_request(ACT_RAW,    32'sd0, 32'sd0);
        push_request(ACT_RAW,    -32'sd1, -32'sd1);
        push_request(ACT_RANGED, 32'sd0, 32'sd1);
        push_request(ACT_RANGED, -32'sd1, 32'sd0);
        push_request(ACT_RANGED, 32'sh8000_0000, 32'sh8000_0001);
        push_request(ACT_RANGED, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF);
        push_request(ACT_RANGED, 32'sh8000_0000, -32'sd1);
        push_request(ACT_RANGED, 32'sd0, 32'sh7FFF_FFFF);
        push_request(ACT_RANGED, -32'sd1, 32'sh7FFF_FFFE);
        push_request(ACT_RANGED, -32'sd1, 32'sh7FFF_FFFF);
        push_request(ACT_RANGED, 32'sh8000_0000, 32'sd0);
        push_request(ACT_RANGED, 32'sh8000_0000, 32'sh7FFF_FFFF);
        push_request(ACT_RANGED, 32'sd5, 32'sd5);
        push_request(ACT_RANGED, 32'sh7FFF_FFFF, 32'sh8000_0000);
        push_request(ACT_RANGED, 32'sd10, -32'sd10);
        push_request(ACT_RANGED, -32'sd100, 32'sd100);
        push_request(ACT_RANGED, 32'sd0, 32'sd1431655766);
        push_request(ACT_RANGED, 32'sd0, 32'sd1431655766);
        push_request(ACT_RANGED, 32'sd7, 32'sd8);
        push_request(ACT_RAW,    32'sh7FFF_FFFF, 32'sh8000_0000);
        wait_drained();

        // Write to an unmapped index: no reseed expected
        write_register(REG_SPARE_LO, {$urandom, $urandom});
        queue_random(20);
        wait_drained();

        // All-zero registers, sender idling, with a full pause midway
        send_idle_pct = 59;
        write_register(REG_SEED_STATE, 64'd0);
        queue_random(10);
        wait_drained();
        write_register(REG_STREAM_SELECT, 64'd0);
        queue_random(150);
        wait_drained();
        queue_random(150);
        wait_drained();

        // All-ones registers, receiver stalling
        send_idle_pct  = 0;
        recv_stall_pct = 59;
        write_register(REG_SEED_STATE, '1);
        queue_random(10);
        wait_drained();
        write_register(REG_STREAM_SELECT, '1);
        queue_random(300);
        wait_drained();

        // Random registers, both sides idling now and then
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        write_register(REG_SPARE_HI, {$urandom, $urandom});
        queue_random(10);
        wait_drained();
        write_register(REG_SEED_STATE, {$urandom, $urandom});
        queue_random(10);
        wait_drained();
        write_register(REG_STREAM_SELECT, {$urandom, $urandom});
        queue_random(300);
        wait_drained();

        // Random registers, no idling, long receiver hold-off to back up the input
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_register(REG_SEED_STATE, {$urandom, $urandom});
        queue_random(10);
        wait_drained();
        write_register(REG_STREAM_SELECT, {$urandom, $urandom});
        holdoff_left = HOLDOFF_LEN;
        queue_random(300);
        wait_drained();

        // Let any stray result surface before the verdict
        repeat (FLUSH_CYCLES) @(posedge clk);
        if (rsp_expected.size() != 0)
            report_failure($sformatf("%0d results never arrived", rsp_expected.size()));
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/pcg32rr_pkg.sv
hdl/pcg32_ranged_random_generator.sv
tb/tb_pcg32_ranged_random_generator.sv
